@@ rtl/core/ab4_pkg.sv @@
// Shared types, widths and constants of the Adams-Bashforth integrator.
`default_nettype none

package ab4_pkg;

   localparam int MAX_DIMS       = 1024;
   localparam int VALUE_WIDTH    = 32;
   localparam int INDEX_WIDTH    = $clog2(MAX_DIMS);
   localparam int SLOT_WIDTH     = 2;
   localparam int REQ_WIDTH      = 2;
   localparam int STEP_WIDTH     = 24;
   localparam int DIMS_WIDTH     = INDEX_WIDTH + 1;
   localparam int TIME_WIDTH     = 40;
   localparam int HIST_WIDTH     = 3 * VALUE_WIDTH;

   localparam int REQ_TDATA_BITS  = INDEX_WIDTH + SLOT_WIDTH + VALUE_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_TDATA_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS  = INDEX_WIDTH + VALUE_WIDTH + TIME_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_TDATA_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_WIDTH   = RSP_TDATA_WIDTH - RSP_TDATA_BITS;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = STEP_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_SIZE   = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ACTIVE_DIMS = 1'b1;

   localparam logic [STEP_WIDTH-1:0] STEP_SIZE_RESET   = STEP_WIDTH'(167772);
   localparam logic [DIMS_WIDTH-1:0] ACTIVE_DIMS_RESET = DIMS_WIDTH'(MAX_DIMS);

   localparam logic [SLOT_WIDTH-1:0] SLOT_OLDEST = 2'd0;
   localparam logic [SLOT_WIDTH-1:0] SLOT_MIDDLE = 2'd1;
   localparam logic [SLOT_WIDTH-1:0] SLOT_NEWEST = 2'd2;

   // Datapath widths of one update.
   localparam int CALC_WIDTH     = 40;
   localparam int MAG_WIDTH      = CALC_WIDTH - 1;
   localparam int PROD_WIDTH     = MAG_WIDTH + STEP_WIDTH;
   localparam int RSUM_WIDTH     = PROD_WIDTH + 1;
   localparam int DIV_SHIFT      = 27;
   localparam int Y_WIDTH        = RSUM_WIDTH - DIV_SHIFT;
   localparam int YL_WIDTH       = 18;
   localparam int YH_WIDTH       = Y_WIDTH - YL_WIDTH;
   localparam int RECIP_HI_SHIFT = YH_WIDTH + 1;
   localparam int APROD_WIDTH    = 2 * YH_WIDTH;
   localparam int QHI_WIDTH      = APROD_WIDTH - RECIP_HI_SHIFT;
   localparam int Z_WIDTH        = YL_WIDTH + 2;
   localparam int RECIP_LO_SHIFT = Z_WIDTH + 1;
   localparam int BPROD_WIDTH    = 2 * Z_WIDTH;
   localparam int QUOT_WIDTH     = QHI_WIDTH + YL_WIDTH;
   localparam int SUM_WIDTH      = QUOT_WIDTH + 2;

   localparam logic [RSUM_WIDTH-1:0] ROUND_OFFSET = RSUM_WIDTH'(3) << (DIV_SHIFT - 1);
   localparam logic [YH_WIDTH-1:0] RECIP_HI = YH_WIDTH'(((1 << RECIP_HI_SHIFT) + 2) / 3);
   localparam logic [Z_WIDTH-1:0]  RECIP_LO = Z_WIDTH'(((1 << RECIP_LO_SHIFT) + 2) / 3);

   localparam logic signed [7:0] COEF_NEW    = 8'sd55;
   localparam logic signed [7:0] COEF_NEWEST = 8'sd59;
   localparam logic signed [7:0] COEF_MIDDLE = 8'sd37;
   localparam logic signed [7:0] COEF_OLDEST = 8'sd9;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef enum logic [REQ_WIDTH-1:0] {
      REQ_LOAD_STATE = 2'd0,
      REQ_LOAD_HIST  = 2'd1,
      REQ_STEP       = 2'd2
   } req_kind_type;

   typedef struct packed {
      logic                   vld;
      req_kind_type           kind;
      logic [INDEX_WIDTH-1:0] idx;
      logic [VALUE_WIDTH-1:0] value;
   } item_ctl_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  time_value;
      logic [VALUE_WIDTH-1:0] state_value;
      logic [INDEX_WIDTH-1:0] out_index;
      logic                   last_elem;
      logic                   saturated;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/core/ab4_delta_pipe.sv @@
// Pipelined increment h/24 times the weighted derivative sum, as sign and magnitude.
`default_nettype none

module ab4_delta_pipe import ab4_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [STEP_WIDTH-1:0]         step_size,
   input  item_ctl_type                  in_ctl,
   input  logic signed [CALC_WIDTH-1:0]  in_p1,
   input  logic signed [CALC_WIDTH-1:0]  in_p2,
   output item_ctl_type                  out_ctl,
   output logic                          out_neg,
   output logic [QUOT_WIDTH-1:0]         out_quot,
   output logic [INDEX_WIDTH-1:0]        pre_idx
);

   item_ctl_type ctl_p_ff, ctl_b_ff, ctl_c_ff, ctl_d_ff, ctl_e_ff, ctl_f_ff;

   logic signed [CALC_WIDTH-1:0] p1_ff, p2_ff;
   logic signed [CALC_WIDTH-1:0] c_sum;
   logic                         neg_b_in, neg_b_ff, neg_c_ff, neg_d_ff, neg_e_ff, neg_f_ff;
   logic [MAG_WIDTH-1:0]         mag_b_in, mag_b_ff;
   logic [PROD_WIDTH-1:0]        m_c_in, m_c_ff;
   logic [RSUM_WIDTH-1:0]        rsum;
   logic [Y_WIDTH-1:0]           y_d_in, y_d_ff;
   logic [APROD_WIDTH-1:0]       aprod_e_in, aprod_e_ff;
   logic [YL_WIDTH-1:0]          yl_e_ff;
   logic [1:0]                   yh_lo_e_ff;
   logic [QHI_WIDTH-1:0]         a_f_in, a_f_ff;
   logic [1:0]                   rem_hi;
   logic [Z_WIDTH-1:0]           z_val;
   logic [BPROD_WIDTH-1:0]       bprod_f_in, bprod_f_ff;

   always_comb begin
      c_sum    = p1_ff + p2_ff;
      neg_b_in = c_sum[CALC_WIDTH-1];
      mag_b_in = neg_b_in ? MAG_WIDTH'(-c_sum) : MAG_WIDTH'(c_sum);
      m_c_in   = PROD_WIDTH'(mag_b_ff) * PROD_WIDTH'(step_size);
      rsum     = RSUM_WIDTH'(m_c_ff) + ROUND_OFFSET;
      y_d_in   = rsum[RSUM_WIDTH-1:DIV_SHIFT];
      aprod_e_in = APROD_WIDTH'(y_d_ff[Y_WIDTH-1:YL_WIDTH]) * APROD_WIDTH'(RECIP_HI);
      a_f_in   = aprod_e_ff[APROD_WIDTH-1:RECIP_HI_SHIFT];
      rem_hi   = yh_lo_e_ff - a_f_in[1:0] - {a_f_in[0], 1'b0};
      z_val    = {rem_hi, yl_e_ff};
      bprod_f_in = BPROD_WIDTH'(z_val) * BPROD_WIDTH'(RECIP_LO);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff <= '0;
         ctl_b_ff <= '0;
         ctl_c_ff <= '0;
         ctl_d_ff <= '0;
         ctl_e_ff <= '0;
         ctl_f_ff <= '0;
      end else if (en) begin
         ctl_p_ff <= in_ctl;
         ctl_b_ff <= ctl_p_ff;
         ctl_c_ff <= ctl_b_ff;
         ctl_d_ff <= ctl_c_ff;
         ctl_e_ff <= ctl_d_ff;
         ctl_f_ff <= ctl_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff      <= in_p1;
         p2_ff      <= in_p2;
         neg_b_ff   <= neg_b_in;
         mag_b_ff   <= mag_b_in;
         neg_c_ff   <= neg_b_ff;
         m_c_ff     <= m_c_in;
         neg_d_ff   <= neg_c_ff;
         y_d_ff     <= y_d_in;
         neg_e_ff   <= neg_d_ff;
         aprod_e_ff <= aprod_e_in;
         yl_e_ff    <= y_d_ff[YL_WIDTH-1:0];
         yh_lo_e_ff <= y_d_ff[YL_WIDTH+1:YL_WIDTH];
         neg_f_ff   <= neg_e_ff;
         a_f_ff     <= a_f_in;
         bprod_f_ff <= bprod_f_in;
      end
   end

   assign out_ctl  = ctl_f_ff;
   assign out_neg  = neg_f_ff;
   assign out_quot = {a_f_ff, bprod_f_ff[RECIP_LO_SHIFT+YL_WIDTH-1:RECIP_LO_SHIFT]};
   assign pre_idx  = ctl_e_ff.idx;

endmodule

`default_nettype wire

@@ rtl/core/adams_bashforth4_integrator_top.sv @@
// Top level of the fourth-order Adams-Bashforth per-element integrator.
// A word passes the input register, the delta-pipe stages p to f and the output register on its way to rsp_tvalid.
// Throughput: one word per cycle while the skid entry is empty, set by one read and one write port per element memory.
// A two-entry output buffer lets input words flow while a result waits.
// Reset clears valid bits, time and configuration; element memories are not cleared.
`default_nettype none

module adams_bashforth4_integrator_top import ab4_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_TDATA_WIDTH-1:0]   req_tdata,  // elem_index, hist_slot, value
   input  logic [REQ_WIDTH-1:0]         req_tuser,  // req_type
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_TDATA_WIDTH-1:0]   rsp_tdata,  // out_index, state_value, time_value
   output logic                         rsp_tlast,
   output logic                         rsp_tuser,  // saturated
   input  logic                         csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]    csr_data
);

   logic [STEP_WIDTH-1:0] step_size_ff;
   logic [DIMS_WIDTH-1:0] active_dims_ff;
   logic [TIME_WIDTH-1:0] time_acc_ff, time_acc_in;

   logic                   pipe_en, req_fire, req_known;
   item_ctl_type           a_ctl_in, a_ctl_ff;
   logic [SLOT_WIDTH-1:0]  a_slot_ff;

   logic [HIST_WIDTH-1:0]  hist_mem [MAX_DIMS];
   logic [HIST_WIDTH-1:0]  hist_rd_ff, hist_cur, hist_new, hbyp_data_ff;
   logic [INDEX_WIDTH-1:0] hbyp_idx_ff;
   logic                   hbyp_vld_ff, hist_we;
   logic signed [CALC_WIDTH-1:0] nw_x, f2_x, f1_x, f0_x, p1, p2;

   item_ctl_type            f_ctl;
   logic                    f_neg;
   logic [QUOT_WIDTH-1:0]   f_quot;
   logic [INDEX_WIDTH-1:0]  pre_idx;

   logic [VALUE_WIDTH-1:0]  state_mem [MAX_DIMS];
   logic [VALUE_WIDTH-1:0]  st_rd_ff, st_cur, st_new, sbyp_val_ff;
   logic [INDEX_WIDTH-1:0]  sbyp_idx_ff;
   logic                    sbyp_vld_ff, st_we, f_fire;
   logic signed [SUM_WIDTH-1:0] st_x, q_x, sum;
   logic                    ovf, f_last, f_sat;
   logic [VALUE_WIDTH-1:0]  clipped;
   result_type              res, out_ff, skid_ff;
   logic                    out_vld_ff, skid_vld_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff   <= STEP_SIZE_RESET;
         active_dims_ff <= ACTIVE_DIMS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STEP_SIZE:   step_size_ff   <= csr_data[STEP_WIDTH-1:0];
            CSR_ACTIVE_DIMS: active_dims_ff <= csr_data[DIMS_WIDTH-1:0];
         endcase
      end
   end

   // Input stage and history read-modify-write.
   assign pipe_en    = !skid_vld_ff;
   assign req_tready = pipe_en;
   assign req_fire   = req_tvalid && pipe_en;

   always_comb begin
      unique case (req_tuser)
         REQ_LOAD_STATE, REQ_LOAD_HIST, REQ_STEP: req_known = 1'b1;
         default:                                 req_known = 1'b0;
      endcase
      a_ctl_in.vld   = req_fire && req_known;
      a_ctl_in.kind  = req_kind_type'(req_tuser);
      a_ctl_in.idx   = req_tdata[INDEX_WIDTH-1:0];
      a_ctl_in.value = req_tdata[INDEX_WIDTH+SLOT_WIDTH+VALUE_WIDTH-1:INDEX_WIDTH+SLOT_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else if (pipe_en) begin
         a_ctl_ff <= a_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         a_slot_ff <= req_tdata[INDEX_WIDTH+SLOT_WIDTH-1:INDEX_WIDTH];
      end
   end

   always_comb begin
      hist_cur = (hbyp_vld_ff && hbyp_idx_ff == a_ctl_ff.idx) ? hbyp_data_ff : hist_rd_ff;
      hist_new = hist_cur;
      hist_we  = 1'b0;
      unique case (a_ctl_ff.kind)
         REQ_STEP: begin
            hist_new = {a_ctl_ff.value, hist_cur[HIST_WIDTH-1:VALUE_WIDTH]};
            hist_we  = 1'b1;
         end
         REQ_LOAD_HIST: begin
            unique case (a_slot_ff)
               SLOT_OLDEST: begin
                  hist_new[VALUE_WIDTH-1:0] = a_ctl_ff.value;
                  hist_we = 1'b1;
               end
               SLOT_MIDDLE: begin
                  hist_new[2*VALUE_WIDTH-1:VALUE_WIDTH] = a_ctl_ff.value;
                  hist_we = 1'b1;
               end
               SLOT_NEWEST: begin
                  hist_new[HIST_WIDTH-1:2*VALUE_WIDTH] = a_ctl_ff.value;
                  hist_we = 1'b1;
               end
               default: hist_we = 1'b0;
            endcase
         end
         default: hist_we = 1'b0;
      endcase
      hist_we = hist_we && a_ctl_ff.vld && pipe_en;

      nw_x = CALC_WIDTH'(signed'(a_ctl_ff.value));
      f2_x = CALC_WIDTH'(signed'(hist_cur[HIST_WIDTH-1:2*VALUE_WIDTH]));
      f1_x = CALC_WIDTH'(signed'(hist_cur[2*VALUE_WIDTH-1:VALUE_WIDTH]));
      f0_x = CALC_WIDTH'(signed'(hist_cur[VALUE_WIDTH-1:0]));
      p1   = COEF_NEW * nw_x - COEF_NEWEST * f2_x;
      p2   = COEF_MIDDLE * f1_x - COEF_OLDEST * f0_x;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hist_rd_ff <= hist_mem[req_tdata[INDEX_WIDTH-1:0]];
      end
      if (hist_we) begin
         hist_mem[a_ctl_ff.idx] <= hist_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hbyp_vld_ff <= 1'b0;
      end else if (hist_we) begin
         hbyp_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hbyp_idx_ff  <= a_ctl_ff.idx;
         hbyp_data_ff <= hist_new;
      end
   end

   ab4_delta_pipe u_delta (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .step_size (step_size_ff),
      .in_ctl    (a_ctl_ff),
      .in_p1     (p1),
      .in_p2     (p2),
      .out_ctl   (f_ctl),
      .out_neg   (f_neg),
      .out_quot  (f_quot),
      .pre_idx   (pre_idx)
   );

   // State update stage.
   always_comb begin
      f_fire  = f_ctl.vld && pipe_en;
      st_cur  = (sbyp_vld_ff && sbyp_idx_ff == f_ctl.idx) ? sbyp_val_ff : st_rd_ff;
      st_x    = SUM_WIDTH'(signed'(st_cur));
      q_x     = signed'(SUM_WIDTH'(f_quot));
      sum     = f_neg ? st_x - q_x : st_x + q_x;
      ovf     = !(&sum[SUM_WIDTH-1:VALUE_WIDTH-1]) && (|sum[SUM_WIDTH-1:VALUE_WIDTH-1]);
      clipped = sum[SUM_WIDTH-1] ? VALUE_MIN : VALUE_MAX;
      f_last  = 1'b0;
      f_sat   = 1'b0;
      st_we   = 1'b0;
      st_new  = st_cur;
      unique case (f_ctl.kind)
         REQ_STEP: begin
            st_new = ovf ? clipped : sum[VALUE_WIDTH-1:0];
            f_sat  = ovf;
            st_we  = 1'b1;
            f_last = (DIMS_WIDTH'({1'b0, f_ctl.idx}) + DIMS_WIDTH'(1)) == active_dims_ff;
         end
         REQ_LOAD_STATE: begin
            st_new = f_ctl.value;
            st_we  = 1'b1;
         end
         default: st_we = 1'b0;
      endcase
      st_we       = st_we && f_fire;
      time_acc_in = f_last ? time_acc_ff + TIME_WIDTH'(step_size_ff) : time_acc_ff;

      res.time_value  = time_acc_in;
      res.state_value = st_new;
      res.out_index   = f_ctl.idx;
      res.last_elem   = f_last;
      res.saturated   = f_sat;
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         st_rd_ff <= state_mem[pre_idx];
      end
      if (st_we) begin
         state_mem[f_ctl.idx] <= st_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sbyp_vld_ff <= 1'b0;
         time_acc_ff <= '0;
      end else begin
         if (st_we) begin
            sbyp_vld_ff <= 1'b1;
         end
         if (f_fire) begin
            time_acc_ff <= time_acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         sbyp_idx_ff <= f_ctl.idx;
         sbyp_val_ff <= st_new;
      end
   end

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_tready) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (!out_vld_ff || rsp_tready) begin
         out_vld_ff <= f_ctl.vld;
      end else if (f_ctl.vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_tready) begin
            out_ff <= skid_ff;
         end
      end else if (!out_vld_ff || rsp_tready) begin
         out_ff <= res;
      end else begin
         skid_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {RSP_PAD_WIDTH'(0), out_ff.time_value, out_ff.state_value,
                        out_ff.out_index};
   assign rsp_tlast  = out_ff.last_elem;
   assign rsp_tuser  = out_ff.saturated;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry holds a word while the output register is empty");

   a_last_matches_count: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.last_elem) |->
         ((DIMS_WIDTH'({1'b0, out_ff.out_index}) + DIMS_WIDTH'(1)) == active_dims_ff))
      else $error("last element flag on a word that is not the last active element");

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.saturated) |->
         (out_ff.state_value == VALUE_MAX || out_ff.state_value == VALUE_MIN))
      else $error("saturated word carries a state value that is not a range limit");

endmodule

`default_nettype wire
